// File: design/hgf_pkg.sv
// ----------------------------------------------------------------------------
// hgf_pkg
// Shared types and constants of the horizontal gradient filter.
// ----------------------------------------------------------------------------
`default_nettype none

package hgf_pkg;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // configuration register map
    localparam int   CFG_IDX_BITS     = 1;
    localparam int   REG_BITS         = 11;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam int   FRAME_WIDTH_RST  = 640;
    localparam int   FRAME_HEIGHT_RST = 480;

    // frame geometry and result fields
    localparam int MAX_HEIGHT   = 1024;
    localparam int ROW_BITS     = 10;
    localparam int OUT_COL_BITS = 10;
    localparam int GRAD_BITS    = 19;

    // result queue
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = 2;
    localparam int OUT_LVL_BITS = 3;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] gradient;
        logic [OUT_COL_BITS-1:0]     out_col;
        logic [ROW_BITS-1:0]         out_row;
        logic                        frame_last;
    } t_result;

endpackage

`default_nettype wire

// File: design/hgf_out_fifo.sv
// ----------------------------------------------------------------------------
// hgf_out_fifo
// Small result queue that parts the filter datapath from the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hgf_out_fifo
    import hgf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire t_result                 i_data,
    input  wire logic                    i_pop,
    output logic                         o_valid,
    output t_result                      o_data,
    output logic [OUT_LVL_BITS-1:0]      o_level
);

    t_result                  r_mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0]  r_wr_ptr;
    logic [OUT_PTR_BITS-1:0]  r_rd_ptr;
    logic [OUT_LVL_BITS-1:0]  r_level;
    logic [OUT_LVL_BITS-1:0]  n_level;

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_level = r_level + 1'b1;
            2'b01:   n_level = r_level - 1'b1;
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

endmodule

`default_nettype wire

// File: design/horizontal_gradient_3x3_filter.sv
// ----------------------------------------------------------------------------
// horizontal_gradient_3x3_filter
// 3x3 horizontal Prewitt gradient over a raster stream with edge replication.
// ----------------------------------------------------------------------------
// The block takes one beat per clock, samples and flush ticks alike, while
// o_stall is low; results pass the compute registers and then the queue.
// The centre at raster position m is finished by the sample at m + width + 1,
// so after the last sample of a frame send width + 1 flush ticks (width for a
// one-row frame) to drain the tail. Both previous rows live in one line store
// of MAX_WIDTH words, each word holding two samples of one column; every
// beat reads one word and a sample beat writes it back, with a bypass for the
// one-column case where consecutive beats hit the same word. The store needs
// no clearing pass: rows not yet written in the current frame are never used.
// Column sums of three rows are formed per beat and a two-deep window of
// those sums gives the gradient. A four-entry queue buffers results, so the
// input only stalls once the output side has stopped taking beats.
// ----------------------------------------------------------------------------
`default_nettype none

module horizontal_gradient_3x3_filter
    import hgf_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire logic [REG_BITS-1:0]           i_cfg_wdata,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [GRAD_BITS-1:0]        o_gradient,
    output logic [OUT_COL_BITS-1:0]            o_out_col,
    output logic [ROW_BITS-1:0]                o_out_row,
    output logic                               o_frame_last
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WORD_BITS = 2 * SAMPLE_BITS;
    localparam int VSUM_BITS = SAMPLE_BITS + 2;
    localparam int DIFF_BITS = SAMPLE_BITS + 3;
    localparam int GEXT_BITS = (DIFF_BITS > GRAD_BITS) ? DIFF_BITS : GRAD_BITS;
    localparam int CEXT_BITS = (COL_BITS > OUT_COL_BITS) ? COL_BITS : OUT_COL_BITS;
    localparam int WCMP_BITS = (COL_BITS + 1 > REG_BITS) ? COL_BITS + 1 : REG_BITS;

    // ------------------------------------------------------------------
    // Configuration registers and the geometry derived from them
    // ------------------------------------------------------------------
    logic [REG_BITS-1:0]  r_frame_width;
    logic [REG_BITS-1:0]  r_frame_height;
    logic [WCMP_BITS-1:0] w_fw_ext;
    logic [COL_BITS-1:0]  w_w_last;
    logic [ROW_BITS-1:0]  w_h_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= REG_BITS'(FRAME_WIDTH_RST);
            r_frame_height <= REG_BITS'(FRAME_HEIGHT_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
            endcase
        end
    end

    // treat zero as one, clip to the largest supported size
    assign w_fw_ext = WCMP_BITS'(r_frame_width);

    always_comb begin
        if (w_fw_ext == '0) begin
            w_w_last = '0;
        end else if (w_fw_ext > WCMP_BITS'(MAX_WIDTH)) begin
            w_w_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_w_last = COL_BITS'(w_fw_ext - WCMP_BITS'(1));
        end
    end

    always_comb begin
        if (r_frame_height == '0) begin
            w_h_last = '0;
        end else if (r_frame_height > REG_BITS'(MAX_HEIGHT)) begin
            w_h_last = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            w_h_last = ROW_BITS'(r_frame_height - REG_BITS'(1));
        end
    end

    // ------------------------------------------------------------------
    // Stream position counters
    // ------------------------------------------------------------------
    logic                 r_in_valid_unused;
    logic [COL_BITS-1:0]  r_in_col, n_in_col;
    logic [ROW_BITS-1:0]  r_in_row, n_in_row;
    logic [COL_BITS-1:0]  r_out_col, n_out_col;
    logic [ROW_BITS-1:0]  r_out_row, n_out_row;
    logic                 r_frame_rcvd, n_frame_rcvd;

    logic                 w_accept;
    logic                 w_is_flush;
    logic [COL_BITS-1:0]  w_ci;
    logic [ROW_BITS-1:0]  w_ri;
    logic [COL_BITS-1:0]  w_oc;
    logic [ROW_BITS-1:0]  w_or;
    logic                 w_c_first;
    logic                 w_c_last;
    logic                 w_res_last;
    logic [COL_BITS-1:0]  w_vc;
    logic [COL_BITS-1:0]  w_raddr;
    logic                 w_emit;
    logic                 w_vev;
    logic                 w_mid_new;
    logic                 w_top_b;
    logic                 w_s1_load;

    assign w_accept   = i_valid && !o_stall;
    assign w_is_flush = (i_cmd == CMD_FLUSH);

    always_comb begin
        // a sample after a received frame drops the pending tail
        w_ci = r_frame_rcvd ? '0 : r_in_col;
        w_ri = r_frame_rcvd ? '0 : r_in_row;
        w_oc = (!w_is_flush && r_frame_rcvd) ? '0 : r_out_col;
        w_or = (!w_is_flush && r_frame_rcvd) ? '0 : r_out_row;

        w_c_first  = (w_oc == '0);
        w_c_last   = (w_oc == w_w_last);
        w_res_last = (w_or == w_h_last) && w_c_last;

        // column sum needed next is the one right of the centre, or the
        // first column of the next row once the centre sits on the right edge
        w_vc    = w_c_last ? '0 : w_oc + 1'b1;
        w_raddr = w_is_flush ? w_vc : w_ci;

        if (w_is_flush) begin
            w_emit    = r_frame_rcvd;
            w_vev     = r_frame_rcvd && !w_res_last;
            w_mid_new = 1'b0;
            w_top_b   = (w_h_last != '0);
        end else begin
            w_emit    = ((w_ri != '0) && (w_ci != '0)) || (w_ri > ROW_BITS'(1));
            w_vev     = (w_ri != '0) || ((w_h_last == '0) && (w_ci == '0));
            w_mid_new = (w_ri == '0);
            w_top_b   = (w_ri > ROW_BITS'(1));
        end

        w_s1_load = w_accept && (!w_is_flush || w_emit);

        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_frame_rcvd = r_frame_rcvd;

        priority if (i_cfg_we) begin
            // any register write restarts the stream
            n_in_col     = '0;
            n_in_row     = '0;
            n_out_col    = '0;
            n_out_row    = '0;
            n_frame_rcvd = 1'b0;
        end else if (w_accept) begin
            if (!w_is_flush) begin
                n_frame_rcvd = 1'b0;
                if (w_ci == w_w_last) begin
                    n_in_col = '0;
                    n_in_row = w_ri + 1'b1;
                    if (w_ri == w_h_last) begin
                        n_frame_rcvd = 1'b1;
                    end
                end else begin
                    n_in_col = w_ci + 1'b1;
                    n_in_row = w_ri;
                end
                n_out_col = w_oc;
                n_out_row = w_or;
            end
            if (w_emit) begin
                if (w_res_last) begin
                    n_in_col     = '0;
                    n_in_row     = '0;
                    n_out_col    = '0;
                    n_out_row    = '0;
                    n_frame_rcvd = 1'b0;
                end else if (w_c_last) begin
                    n_out_col = '0;
                    n_out_row = w_or + 1'b1;
                end else begin
                    n_out_col = w_oc + 1'b1;
                    n_out_row = w_or;
                end
            end
        end
    end

    assign r_in_valid_unused = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_frame_rcvd <= 1'b0;
        end else begin
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_frame_rcvd <= n_frame_rcvd;
        end
    end

    // ------------------------------------------------------------------
    // Line store: word holds {row two above, row above} for one column
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] r_line_mem [MAX_WIDTH];
    logic [WORD_BITS-1:0] r_mem_q;
    logic [WORD_BITS-1:0] r_fwd_data;
    logic                 r_fwd_hit;
    logic                 w_mem_we;
    logic [COL_BITS-1:0]  w_waddr;
    logic [WORD_BITS-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_line_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_line_mem[w_raddr];
    end

    // bypass a write that lands on the word being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= w_mem_we && (w_waddr == w_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_wdata;
    end

    // ------------------------------------------------------------------
    // Compute stage
    // ------------------------------------------------------------------
    logic                          r_s1_valid;
    logic                          r_s1_flush;
    logic                          r_s1_emit;
    logic                          r_s1_vev;
    logic                          r_s1_mid_new;
    logic                          r_s1_top_b;
    logic                          r_s1_c_first;
    logic                          r_s1_c_last;
    logic                          r_s1_last;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic [COL_BITS-1:0]           r_s1_col;
    logic [COL_BITS-1:0]           r_s1_out_col;
    logic [ROW_BITS-1:0]           r_s1_out_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_s1_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_flush   <= w_is_flush;
            r_s1_emit    <= w_emit;
            r_s1_vev     <= w_vev;
            r_s1_mid_new <= w_mid_new;
            r_s1_top_b   <= w_top_b;
            r_s1_c_first <= w_c_first;
            r_s1_c_last  <= w_c_last;
            r_s1_last    <= w_res_last;
            r_s1_sample  <= i_sample;
            r_s1_col     <= w_ci;
            r_s1_out_col <= w_oc;
            r_s1_out_row <= w_or;
        end
    end

    logic [WORD_BITS-1:0]          w_rd_word;
    logic signed [SAMPLE_BITS-1:0] w_rd_a;
    logic signed [SAMPLE_BITS-1:0] w_rd_b;
    logic signed [SAMPLE_BITS-1:0] w_top;
    logic signed [SAMPLE_BITS-1:0] w_mid;
    logic signed [SAMPLE_BITS-1:0] w_bot;
    logic signed [VSUM_BITS-1:0]   w_vsum;
    logic signed [VSUM_BITS-1:0]   r_win_a;
    logic signed [VSUM_BITS-1:0]   r_win_b;
    logic signed [VSUM_BITS-1:0]   w_left;
    logic signed [VSUM_BITS-1:0]   w_right;
    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [GEXT_BITS-1:0]   w_grad_ext;
    logic [CEXT_BITS-1:0]          w_col_ext;

    assign w_rd_word = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign w_rd_a    = $signed(w_rd_word[SAMPLE_BITS-1:0]);
    assign w_rd_b    = $signed(w_rd_word[WORD_BITS-1:SAMPLE_BITS]);

    // row clamping: the first row stands in for the one above it, the
    // last row for the one below it
    assign w_bot  = r_s1_flush ? w_rd_a : r_s1_sample;
    assign w_mid  = r_s1_mid_new ? r_s1_sample : w_rd_a;
    assign w_top  = r_s1_top_b ? w_rd_b : w_mid;
    assign w_vsum = VSUM_BITS'(w_top) + VSUM_BITS'(w_mid) + VSUM_BITS'(w_bot);

    // age the row above into the upper half of the word
    assign w_mem_we = r_s1_valid && !r_s1_flush;
    assign w_waddr  = r_s1_col;
    assign w_wdata  = {w_rd_a, r_s1_sample};

    // column clamping: the centre column replaces a missing neighbour
    assign w_left     = r_s1_c_first ? r_win_b : r_win_a;
    assign w_right    = r_s1_c_last ? r_win_b : w_vsum;
    assign w_diff     = DIFF_BITS'(w_left) - DIFF_BITS'(w_right);
    assign w_grad_ext = GEXT_BITS'(w_diff);
    assign w_col_ext  = CEXT_BITS'(r_s1_out_col);

    // advance the column-sum window on every new sum
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_vev) begin
            r_win_a <= r_win_b;
            r_win_b <= w_vsum;
        end
    end

    // ------------------------------------------------------------------
    // Result queue and handshakes
    // ------------------------------------------------------------------
    t_result                  w_push_data;
    t_result                  w_q_data;
    logic                     w_push;
    logic                     w_pop;
    logic [OUT_LVL_BITS-1:0]  w_level;
    logic [OUT_LVL_BITS-1:0]  w_occ;

    assign w_push                 = r_s1_valid && r_s1_emit;
    assign w_push_data.gradient   = w_grad_ext[GRAD_BITS-1:0];
    assign w_push_data.out_col    = w_col_ext[OUT_COL_BITS-1:0];
    assign w_push_data.out_row    = r_s1_out_row;
    assign w_push_data.frame_last = r_s1_last;
    assign w_pop                  = o_valid && !i_stall;

    hgf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (w_q_data),
        .o_level (w_level)
    );

    // hold the input once queued plus in-flight results fill the queue
    assign w_occ   = w_level + OUT_LVL_BITS'(w_push) + OUT_LVL_BITS'(r_in_valid_unused);
    assign o_stall = (w_occ >= OUT_LVL_BITS'(OUT_DEPTH));

    assign o_gradient   = w_q_data.gradient;
    assign o_out_col    = w_q_data.out_col;
    assign o_out_row    = w_q_data.out_row;
    assign o_frame_last = w_q_data.frame_last;

endmodule

`default_nettype wire

// File: design/hgf_checker.sv
// ----------------------------------------------------------------------------
// hgf_checker
// Port-level checks on the horizontal gradient filter, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hgf_checker
    import hgf_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic signed [GRAD_BITS-1:0] o_gradient,
    input wire logic [OUT_COL_BITS-1:0]    o_out_col,
    input wire logic [ROW_BITS-1:0]        o_out_row,
    input wire logic                       o_frame_last
);

    // a stalled result beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat withdrawn while stalled");

    // and keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_gradient) && $stable(o_out_col)
                               && $stable(o_out_row) && $stable(o_frame_last))
        else $error("result payload changed while stalled");

    // a newly offered result traces back to an earlier accepted input beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result appeared without a matching input beat");

    // with the output side drained the input is always taken
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while no result is waiting");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result offered straight after reset");

endmodule

bind horizontal_gradient_3x3_filter hgf_checker u_hgf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_gradient   (o_gradient),
    .o_out_col    (o_out_col),
    .o_out_row    (o_out_row),
    .o_frame_last (o_frame_last)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - horizontal gradient filter testbench
// Drives raster frames and flush ticks into the filter under random source
// gaps and sink stalls. A scoreboard predicts every gradient beat, checks the
// output stream in order and counts mismatches.
// ----------------------------------------------------------------------------

import hgf_pkg::*;

// Tracks the filter's geometry, sample history and counters. It predicts the
// result beats that accepted input beats cause and holds those beats until
// the output side delivers them.
class gradient_scoreboard #(int unsigned MAX_W = 1024);

    localparam int unsigned HIST_DEPTH = 2 * MAX_W + 3;

    logic [REG_BITS-1:0] width_reg;
    logic [REG_BITS-1:0] height_reg;
    logic signed [15:0]  history [HIST_DEPTH];
    int unsigned         in_col;
    int unsigned         in_row;
    int unsigned         out_col;
    int unsigned         out_row;
    bit                  frame_done;
    t_result             pending_gradients [$];
    int unsigned         mismatches;

    function new();
        width_reg  = REG_BITS'(FRAME_WIDTH_RST);
        height_reg = REG_BITS'(FRAME_HEIGHT_RST);
        foreach (history[i]) history[i] = '0;
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        frame_done = 1'b0;
    endfunction

    function int unsigned used_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return width_reg;
    endfunction

    function int unsigned used_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function int unsigned pending();
        return pending_gradients.size();
    endfunction

    // every write restarts the stream
    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] value);
        if (idx == REG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
        restart();
    endfunction

    function int tap(int unsigned row, int unsigned col, int unsigned w);
        return int'(history[(row * w + col) % HIST_DEPTH]);
    endfunction

    // Gradient at the current output centre, with rows and columns clamped
    // to the frame; advance the output position or finish the frame.
    function void predict_gradient(int unsigned w, int unsigned h);
        t_result     want;
        int          g;
        int unsigned left;
        int unsigned right;
        int unsigned rows [3];
        bit          last;
        left    = (out_col > 0) ? out_col - 1 : 0;
        right   = (out_col + 1 < w) ? out_col + 1 : w - 1;
        rows[0] = (out_row > 0) ? out_row - 1 : 0;
        rows[1] = out_row;
        rows[2] = (out_row + 1 < h) ? out_row + 1 : h - 1;
        g = 0;
        foreach (rows[k]) g += tap(rows[k], left, w) - tap(rows[k], right, w);
        last = (out_row == h - 1) && (out_col == w - 1);
        want.gradient   = g[GRAD_BITS-1:0];
        want.out_col    = out_col[OUT_COL_BITS-1:0];
        want.out_row    = out_row[ROW_BITS-1:0];
        want.frame_last = last;
        pending_gradients.push_back(want);
        if (last) begin
            restart();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function void accept_beat(logic cmd, logic signed [15:0] sample);
        int unsigned w;
        int unsigned h;
        int unsigned pos;
        w = used_width();
        h = used_height();
        if (cmd == CMD_FLUSH) begin
            if (frame_done) predict_gradient(w, h);
            return;
        end
        // a sample while a tail is pending drops that tail
        if (frame_done) restart();
        pos = in_row * w + in_col;
        history[pos % HIST_DEPTH] = sample;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) frame_done = 1'b1;
        end
        if (pos >= w + 1) predict_gradient(w, h);
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (pending_gradients.size() == 0) begin
            $display("%0t: unexpected result: gradient %0d col %0d row %0d last %0b",
                     $time, got.gradient, got.out_col, got.out_row, got.frame_last);
            mismatches++;
            return;
        end
        want = pending_gradients.pop_front();
        if (got !== want) begin
            $display("%0t: mismatch: expected gradient %0d col %0d row %0d last %0b",
                     $time, want.gradient, want.out_col, want.out_row, want.frame_last);
            $display("%0t:           actual gradient %0d col %0d row %0d last %0b",
                     $time, got.gradient, got.out_col, got.out_row, got.frame_last);
            mismatches++;
        end
    endfunction

endclass

module tb;

    localparam int unsigned MAX_WIDTH     = 1024;
    localparam int unsigned RANDOM_ITEMS  = 1000;
    // cycles to let the pipeline settle once nothing is expected any more
    localparam int unsigned LATENCY_SLACK = 16;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;

    typedef enum {FRAME_ANY, FRAME_CLEAN, FRAME_CUT_DRAIN, FRAME_CUT_SHORT} frame_style_e;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_BITS-1:0]     i_cfg_idx;
    logic [REG_BITS-1:0]         i_cfg_wdata;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_cmd;
    logic signed [15:0]          i_sample;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [GRAD_BITS-1:0] o_gradient;
    logic [OUT_COL_BITS-1:0]     o_out_col;
    logic [ROW_BITS-1:0]         o_out_row;
    logic                        o_frame_last;

    gradient_scoreboard #(MAX_WIDTH) sb;

    // calm: no source gaps and no sink stalls for the current phase
    bit          calm;
    int unsigned random_items;

    horizontal_gradient_3x3_filter #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (16)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_gradient   (o_gradient),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short runs, now and then a long one.
    function automatic int unsigned pick_len();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic int unsigned pick_gap();
        if (calm || $urandom_range(0, 99) < 65) return 0;
        return pick_len();
    endfunction

    // Lean on the rails now and then so the gradient reaches its extremes.
    function automatic logic signed [15:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'sh7fff;
        if (r < 16) return 16'sh8000;
        return 16'($urandom);
    endfunction

    // Frame dimension register: zero now and then, mostly tiny, a few larger.
    function automatic logic [REG_BITS-1:0] pick_dim(int unsigned big);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 15) return REG_BITS'($urandom_range(1, 8));
        return REG_BITS'($urandom_range(9, big));
    endfunction

    // Present one beat after a random gap and hold it until the filter takes
    // it. Valid stays high on exit so back-to-back beats need no extra step.
    task automatic send_beat(input logic cmd, input logic signed [15:0] sample);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid  <= 1'b0;
            i_cmd    <= 1'($urandom);
            i_sample <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_sample <= sample;
        do @(posedge i_clk); while (o_stall);
        sb.accept_beat(cmd, sample);
    endtask

    // the sample field of a flush is don't-care: drive noise into it
    task automatic send_flush();
        send_beat(CMD_FLUSH, 16'($urandom));
    endtask

    // Drop valid, wait for every predicted beat, then let the pipeline settle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    // One write per call; lower the enable on the following edge.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [REG_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // One raster frame, then its tail of flush ticks. A cut drain leaves part
    // of the tail behind for the next frame to drop; a short cut stops partway
    // through the samples and the next register write restarts the stream.
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input frame_style_e style);
        int unsigned total;
        int unsigned count;
        int unsigned tail;
        int unsigned flushes;
        total = w * h;
        tail  = (h == 1) ? w : w + 1;
        count = total;
        if (style == FRAME_CUT_SHORT && total > 1) begin
            count = (total > 1200) ? $urandom_range(1100, 1200) : $urandom_range(1, total - 1);
        end
        for (int unsigned i = 0; i < count; i++) begin
            // stray flush: ignored mid-frame, or eats a leftover tail
            if ($urandom_range(0, 49) == 0) send_flush();
            // hold off until the output side has caught up
            if ($urandom_range(0, 199) == 0) wait_drained();
            send_beat(CMD_SAMPLE, pick_sample());
            random_items++;
        end
        case (style)
            FRAME_CLEAN: begin
                for (int unsigned i = 0; i < tail; i++) begin
                    send_flush();
                    random_items++;
                end
                // extra ticks on an idle block
                flushes = $urandom_range(0, 2);
                repeat (flushes) send_flush();
            end
            FRAME_CUT_DRAIN: begin
                flushes = $urandom_range(0, tail - 1);
                for (int unsigned i = 0; i < flushes; i++) begin
                    send_flush();
                    random_items++;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Idle the block, program the geometry, then stream a few frames.
    task automatic run_phase(input logic [REG_BITS-1:0] w_reg,
                             input logic [REG_BITS-1:0] h_reg,
                             input bit write_w, input bit write_h,
                             input int unsigned frames, input frame_style_e style);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        frame_style_e this_style;
        wait_drained();
        calm = ($urandom_range(0, 4) == 0);
        if (write_w) write_reg(REG_FRAME_WIDTH, w_reg);
        if (write_h) write_reg(REG_FRAME_HEIGHT, h_reg);
        w = sb.used_width();
        h = sb.used_height();
        for (int unsigned f = 0; f < frames; f++) begin
            this_style = style;
            if (style == FRAME_ANY) begin
                r = $urandom_range(0, 99);
                if (r < 70) this_style = FRAME_CLEAN;
                else if (r < 85) this_style = FRAME_CUT_DRAIN;
                else this_style = FRAME_CUT_SHORT;
            end
            run_frame(w, h, this_style);
            if (this_style == FRAME_CUT_SHORT) break;
        end
    endtask

    // Sink side: check each delivered beat, then decide the next stall cycle.
    initial begin : result_side
        t_result     seen;
        int unsigned stall_left;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                seen.gradient   = o_gradient;
                seen.out_col    = o_out_col;
                seen.out_row    = o_out_row;
                seen.frame_last = o_frame_last;
                sb.check_result(seen);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_len();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int unsigned r;
        sb           = new();
        calm         = 1'b0;
        random_items = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_FRAME_WIDTH;
        i_cfg_wdata <= '0;
        i_valid     <= 1'b0;
        i_cmd       <= CMD_SAMPLE;
        i_sample    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry is 640 x 480: a couple of samples complete nothing.
        send_beat(CMD_SAMPLE, 16'sh7fff);
        send_beat(CMD_SAMPLE, 16'sh8000);
        wait_drained();

        // 3 x 3 frame of alternating rails: edge columns hit both extremes of
        // the gradient, the middle column cancels to zero.
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        for (int unsigned i = 0; i < 9; i++) begin
            if (i == 4) send_flush();       // flush mid-frame: ignored
            if (i == 5) wait_drained();     // hold off until caught up
            send_beat(CMD_SAMPLE, (i % 3 == 1) ? 16'sh8000 : 16'sh7fff);
        end
        // four tail ticks, then one on an idle block
        repeat (5) send_flush();
        wait_drained();

        // single sample frame
        write_reg(REG_FRAME_WIDTH, 11'd1);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        send_beat(CMD_SAMPLE, -16'sd1);
        send_flush();
        wait_drained();

        // 2 x 1: a new frame starts while one tail beat is still pending
        write_reg(REG_FRAME_WIDTH, 11'd2);
        send_beat(CMD_SAMPLE, pick_sample());
        send_beat(CMD_SAMPLE, pick_sample());
        send_flush();
        send_beat(CMD_SAMPLE, pick_sample());
        send_beat(CMD_SAMPLE, pick_sample());
        send_flush();
        send_flush();

        // Register extremes: zero clamps to one, oversize clamps to the
        // maximum; the full 1024-square frame is cut short.
        run_phase(11'd0, 11'd0, 1'b1, 1'b1, 2, FRAME_CLEAN);
        run_phase(11'd2047, 11'd1, 1'b1, 1'b1, 1, FRAME_CLEAN);
        run_phase(11'd1, 11'd2047, 1'b1, 1'b1, 1, FRAME_CLEAN);
        run_phase(11'd1024, 11'd1024, 1'b1, 1'b1, 1, FRAME_CUT_SHORT);

        // Random geometry, mostly small; sometimes write only one register.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            run_phase(pick_dim(32), pick_dim(12), r != 9, (r < 7) || (r == 9),
                      $urandom_range(1, 3), FRAME_ANY);
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
